// File: sv/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/remsw_pkg.sv
// Constants and types for the remote switch pulse frame encoder.
// Used by the top level; depends on nothing.
`default_nettype none
package remsw_pkg;
	localparam int DUR_W = 24;
	localparam int CNT_W = 6;
	localparam int SYM_N = 12;
	localparam int DIP_N = 10;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int MODE_W = 2;

	localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(49);
	localparam logic [CNT_W-1:0] SYNC_PULSE = CNT_W'(48);

	localparam logic [DUR_W-1:0] HU_SHORT_US = DUR_W'(340);
	localparam logic [DUR_W-1:0] HU_LONG_US = DUR_W'(1020);
	localparam logic [DUR_W-1:0] HU_SYNC_US = DUR_W'(32 * 340);
	localparam logic [DUR_W-1:0] DIP_SHORT_US = DUR_W'(320);
	localparam logic [DUR_W-1:0] DIP_LONG_US = DUR_W'(960);
	localparam logic [DUR_W-1:0] DIP_SYNC_US = DUR_W'(32 * 320);

	localparam logic [2:0] FIXED_CODE = 3'h6;

	localparam logic [MODE_W-1:0] MODE_HOUSE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HOUSE_CLR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DIP = 2'd2;

	localparam logic [1:0] PH_PULSE_A = 2'd0;
	localparam logic [1:0] PH_SPACE_A = 2'd1;
	localparam logic [1:0] PH_PULSE_B = 2'd2;
	localparam logic [1:0] PH_SPACE_B = 2'd3;

	typedef struct packed {
		logic is_pulse;
		logic [DUR_W-1:0] duration_us;
		logic last_of_frame;
	} result_t;
endpackage
`default_nettype wire

// File: sv/remote_switch_pulse_frame_encoder_unit.sv
// Remote switch pulse frame encoder: 50 results per item, one per cycle.
// Accept loads active_q/cnt_q; valid_q/res_q then register the 50 results back to back.
// A new item is accepted in the last counter cycle, so frames stream back to back.
// Throughput is set by the single result port and the 50-step frame counter.
// Reset clears the mode register to house/unit code and leaves the block idle.
// Results cannot be stalled by the receiver. Depends on remsw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module remote_switch_pulse_frame_encoder_unit
	import remsw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input wire logic start,
	output logic busy,
	input wire logic [3:0] house_code,
	input wire logic [DIP_N-1:0] channel_code,
	input wire logic switch_on,
	output logic result_valid,
	output logic is_pulse,
	output logic [DUR_W-1:0] duration_us,
	output logic last_of_frame
);
	logic [MODE_W-1:0] mode_q;
	logic active_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SYM_N-1:0] sym_q;
	logic dip_q;
	logic valid_q;
	result_t res_q;

	logic accept;
	logic cfg_wr;
	logic is_dip;
	logic [SYM_N-1:0] sym_d;
	logic [15:0] sym_pad;
	logic x_shape;
	logic [DUR_W-1:0] dur_s;
	logic [DUR_W-1:0] dur_l;
	logic [DUR_W-1:0] dur_sync;
	result_t res_d;

	assign pready = 1'b1;
	assign prdata = {{(DATA_W-MODE_W){1'b0}}, mode_q};
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == 1'b0);

	assign busy = active_q && (cnt_q != FRAME_LAST);
	assign accept = start && !busy;
	assign is_dip = mode_q[1];

	always_comb begin
		if (is_dip) begin
			sym_d = {switch_on, !switch_on, ~channel_code};
		end else if (mode_q == MODE_HOUSE_CLR && !switch_on) begin
			sym_d = {4'b0000, channel_code[3:0], house_code};
		end else begin
			sym_d = {switch_on, FIXED_CODE, channel_code[3:0], house_code};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HOUSE;
		end else if (cfg_wr) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q <= '0;
		end else if (active_q) begin
			if (cnt_q == FRAME_LAST) begin
				active_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= sym_d;
			dip_q <= is_dip;
		end
	end

	assign sym_pad = {{(16-SYM_N){1'b0}}, sym_q};
	assign x_shape = sym_pad[cnt_q[5:2]];
	assign dur_s = dip_q ? DIP_SHORT_US : HU_SHORT_US;
	assign dur_l = dip_q ? DIP_LONG_US : HU_LONG_US;
	assign dur_sync = dip_q ? DIP_SYNC_US : HU_SYNC_US;

	always_comb begin
		res_d.last_of_frame = 1'b0;
		if (cnt_q == SYNC_PULSE) begin
			res_d.is_pulse = 1'b1;
			res_d.duration_us = dur_s;
		end else if (cnt_q == FRAME_LAST) begin
			res_d.is_pulse = 1'b0;
			res_d.duration_us = dur_sync;
			res_d.last_of_frame = 1'b1;
		end else begin
			case (cnt_q[1:0])
				PH_PULSE_A: begin
					res_d.is_pulse = 1'b1;
					res_d.duration_us = dur_s;
				end
				PH_SPACE_A: begin
					res_d.is_pulse = 1'b0;
					res_d.duration_us = dur_l;
				end
				PH_PULSE_B: begin
					res_d.is_pulse = 1'b1;
					res_d.duration_us = x_shape ? dur_l : dur_s;
				end
				PH_SPACE_B: begin
					res_d.is_pulse = 1'b0;
					res_d.duration_us = x_shape ? dur_s : dur_l;
				end
				default: begin
					res_d.is_pulse = 1'b0;
					res_d.duration_us = dur_l;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign result_valid = valid_q;
	assign is_pulse = res_q.is_pulse;
	assign duration_us = res_q.duration_us;
	assign last_of_frame = res_q.last_of_frame && valid_q;

	`ASSERT_AT(a_accept_restarts, clk, arst_n, accept |=> (active_q && cnt_q == '0), "accepted item did not restart the frame counter")
	`ASSERT_AT(a_busy_active, clk, arst_n, busy |-> active_q, "busy while no frame is running")
	`ASSERT_AT(a_last_follows, clk, arst_n, (active_q && cnt_q == FRAME_LAST) |=> (result_valid && last_of_frame), "final counter step did not produce the sync space")
	`ASSERT_NEVER(a_last_is_space, clk, arst_n, last_of_frame && is_pulse, "sync item marked as a pulse")
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, active_q && (cnt_q > FRAME_LAST), "frame counter ran past the last item")
endmodule
`default_nettype wire
